/* sv/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;

  localparam int HEAP_UNITS_MAX = 4096;
  localparam int UNIT_BYTES     = 16;
  localparam int ADDR_W         = 48;
  localparam int COUNT_W        = 17;
  localparam int UNIT_W         = $clog2(HEAP_UNITS_MAX);
  localparam int SIZE_W         = UNIT_W + 1;
  localparam int SUM_W          = SIZE_W + 1;
  localparam int UNIT_SHIFT     = $clog2(UNIT_BYTES);
  localparam int Q_W            = ADDR_W - UNIT_SHIFT;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_UNITS   = 2'd1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_REJECT  = 2'd3
  } ffa_status_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffa_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_ROOT,
    S_A_NODE,
    S_A_SPLIT,
    S_F_CHK,
    S_F_SIZE,
    S_F_WALK,
    S_F_PREV,
    S_F_NEXT,
    S_F_MERGE,
    S_DONE
  } ffa_state_t;

endpackage
`default_nettype wire

/* sv/first_fit_free_list_allocator.sv */
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_opcode, in_byte_count, in_block_address
// out     | output    | out_valid, out_ready, out_status, out_block_address_out
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One item at a time. Allocate: a root read, a read per free-list node visited, a split step
// if the block is larger than needed. Free: address and size checks, a walk over the nodes,
// link and merge (merged into the previous-block read when the freed block joins the only
// free block from below). Zero-size requests and address or size rejects skip the walk; a
// reject found by the walk or the overlap checks ends it. The walk is bound by one header
// memory read per node. After reset, a clearing pass zeroes the size headers before any item.
// A heap_units write rewrites unit 0 as the single free block before the next item.
// A result waiting in the output register stalls the sequencer only at its last step.
`default_nettype none
module first_fit_free_list_allocator
  import ffa_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [0:0]           in_opcode,
  input  wire  [COUNT_W-1:0]   in_byte_count,
  input  wire  [ADDR_W-1:0]    in_block_address,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_block_address_out,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [ADDR_W-1:0]    cfg_data
);

  logic [UNIT_W-1:0] nf_mem [HEAP_UNITS_MAX];
  logic [SIZE_W-1:0] bu_mem [HEAP_UNITS_MAX];
  logic [UNIT_W-1:0] nf_q;
  logic [SIZE_W-1:0] bu_q;
  logic [UNIT_W-1:0] rd_addr;
  logic              nf_we, bu_we;
  logic [UNIT_W-1:0] nf_wa, bu_wa, nf_wd;
  logic [SIZE_W-1:0] bu_wd;

  ffa_state_t        state_r, state_nxt;
  logic [UNIT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              init_pend_r, init_pend_nxt;
  logic [UNIT_W-1:0] rover_r, rover_nxt;
  logic              list_valid_r, list_valid_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [SIZE_W-1:0] heap_r, heap_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [UNIT_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [SIZE_W-1:0] iter_r, iter_nxt;
  logic [UNIT_W-1:0] fb_r, fb_nxt, p_r, p_nxt, nx_r, nx_nxt, fbnext_r, fbnext_nxt;
  logic [SIZE_W-1:0] sz_r, sz_nxt, bup_r, bup_nxt, fbsz_r, fbsz_nxt;
  logic [ADDR_W-1:0] diff_r, diff_nxt;
  ffa_status_t       res_st_r, res_st_nxt;
  logic [UNIT_W-1:0] res_unit_r, res_unit_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic              in_xfer, cfg_heap_we;
  logic [SIZE_W-1:0] heap_clamp;
  logic [Q_W-1:0]    q, q_m1;
  logic [UNIT_W-1:0] fb_calc;
  logic [COUNT_W:0]  bc_round;
  logic [SUM_W-1:0]  fb_end, p_end;
  logic [SIZE_W-1:0] limit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && !init_pend_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_block_address_out = out_addr_r;
  assign cfg_heap_we = cfg_valid && (cfg_index == CFG_HEAP_UNITS);
  assign limit = SIZE_W'(HEAP_UNITS_MAX);

  always_comb begin
    heap_clamp = cfg_data[SIZE_W-1:0];
    if (heap_clamp < SIZE_W'(2)) begin
      heap_clamp = SIZE_W'(2);
    end else if (heap_clamp > limit) begin
      heap_clamp = limit;
    end
  end

  assign q        = diff_r[ADDR_W-1:UNIT_SHIFT];
  assign q_m1     = q - Q_W'(1);
  assign fb_calc  = q_m1[UNIT_W-1:0];
  assign bc_round = (COUNT_W+1)'(in_byte_count) + (COUNT_W+1)'(UNIT_BYTES - 1);
  assign fb_end   = SUM_W'(fb_r) + SUM_W'(sz_r);
  assign p_end    = SUM_W'(p_r) + SUM_W'(bu_q);

  always_ff @(posedge clk) begin
    if (nf_we) begin
      nf_mem[nf_wa] <= nf_wd;
    end
    if (bu_we) begin
      bu_mem[bu_wa] <= bu_wd;
    end
    nf_q <= nf_mem[rd_addr];
    bu_q <= bu_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    init_pend_nxt  = init_pend_r;
    rover_nxt      = rover_r;
    list_valid_nxt = list_valid_r;
    base_nxt       = base_r;
    heap_nxt       = heap_r;
    need_nxt       = need_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    iter_nxt       = iter_r;
    fb_nxt         = fb_r;
    p_nxt          = p_r;
    nx_nxt         = nx_r;
    fbnext_nxt     = fbnext_r;
    sz_nxt         = sz_r;
    bup_nxt        = bup_r;
    fbsz_nxt       = fbsz_r;
    diff_nxt       = diff_r;
    res_st_nxt     = res_st_r;
    res_unit_nxt   = res_unit_r;
    res_hit_nxt    = res_hit_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    rd_addr = cur_r;
    nf_we = 1'b0;
    nf_wa = '0;
    nf_wd = '0;
    bu_we = 1'b0;
    bu_wa = '0;
    bu_wd = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        nf_we = 1'b1;
        nf_wa = clr_cnt_r;
        bu_we = 1'b1;
        bu_wa = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + UNIT_W'(1);
        if (clr_cnt_r == UNIT_W'(HEAP_UNITS_MAX - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_hit_nxt = 1'b0;
        if (init_pend_r) begin
          // rewrite unit 0 as the single free block
          nf_we = 1'b1;
          bu_we = 1'b1;
          bu_wd = heap_r;
          init_pend_nxt = 1'b0;
        end else if (in_xfer) begin
          if (in_opcode == OP_ALLOC) begin
            if (in_byte_count == '0) begin
              res_st_nxt = ST_ZERO;
              state_nxt  = S_DONE;
            end else if (!list_valid_r) begin
              res_st_nxt = ST_NOSPACE;
              state_nxt  = S_DONE;
            end else begin
              need_nxt  = SIZE_W'(bc_round >> UNIT_SHIFT) + SIZE_W'(1);
              prev_nxt  = rover_r;
              rd_addr   = rover_r;
              iter_nxt  = '0;
              state_nxt = S_A_ROOT;
            end
          end else begin
            if (in_block_address == '0) begin
              res_st_nxt = ST_REJECT;
              state_nxt  = S_DONE;
            end else begin
              diff_nxt  = in_block_address - base_r;
              state_nxt = S_F_CHK;
            end
          end
        end
      end
      S_A_ROOT: begin
        cur_nxt   = nf_q;
        rd_addr   = nf_q;
        state_nxt = S_A_NODE;
      end
      S_A_NODE: begin
        if (bu_q >= need_r) begin
          rover_nxt  = prev_r;
          res_st_nxt = ST_DONE;
          if (bu_q == need_r) begin
            if (cur_r == prev_r) begin
              list_valid_nxt = 1'b0;
            end else begin
              nf_we = 1'b1;
              nf_wa = prev_r;
              nf_wd = nf_q;
            end
            res_unit_nxt = cur_r;
            res_hit_nxt  = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            // keep the head of the block, hand out its tail
            bu_we = 1'b1;
            bu_wa = cur_r;
            bu_wd = bu_q - need_r;
            cur_nxt   = cur_r + UNIT_W'(bu_q - need_r);
            state_nxt = S_A_SPLIT;
          end
        end else if (cur_r == rover_r || iter_r == limit) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = nf_q;
          rd_addr  = nf_q;
          iter_nxt = iter_r + SIZE_W'(1);
        end
      end
      S_A_SPLIT: begin
        bu_we = 1'b1;
        bu_wa = cur_r;
        bu_wd = need_r;
        res_unit_nxt = cur_r;
        res_hit_nxt  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_F_CHK: begin
        if (diff_r[UNIT_SHIFT-1:0] != '0 || q == '0 || q > Q_W'(heap_r)) begin
          res_st_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end else begin
          fb_nxt    = fb_calc;
          rd_addr   = fb_calc;
          state_nxt = S_F_SIZE;
        end
      end
      S_F_SIZE: begin
        sz_nxt = bu_q;
        if (bu_q == '0 || (SUM_W'(fb_r) + SUM_W'(bu_q)) > SUM_W'(heap_r)) begin
          res_st_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end else if (!list_valid_r) begin
          nf_we = 1'b1;
          nf_wa = fb_r;
          nf_wd = fb_r;
          rover_nxt      = fb_r;
          list_valid_nxt = 1'b1;
          res_st_nxt     = ST_DONE;
          state_nxt      = S_DONE;
        end else begin
          p_nxt     = rover_r;
          rd_addr   = rover_r;
          iter_nxt  = '0;
          state_nxt = S_F_WALK;
        end
      end
      S_F_WALK: begin
        nx_nxt = nf_q;
        if (fb_r > p_r && fb_r < nf_q) begin
          rd_addr   = p_r;
          state_nxt = S_F_PREV;
        end else if (fb_r == p_r || fb_r == nf_q) begin
          res_st_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end else if (p_r >= nf_q && (fb_r > p_r || fb_r < nf_q)) begin
          // wrap point of the circular list
          rd_addr   = p_r;
          state_nxt = S_F_PREV;
        end else if (iter_r == limit) begin
          res_st_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end else begin
          p_nxt    = nf_q;
          rd_addr  = nf_q;
          iter_nxt = iter_r + SIZE_W'(1);
        end
      end
      S_F_PREV: begin
        bup_nxt = bu_q;
        if ((fb_r > p_r && p_end > SUM_W'(fb_r)) ||
            (fb_r < nx_r && fb_end > SUM_W'(nx_r))) begin
          res_st_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end else if (nx_r == p_r && fb_end == SUM_W'(p_r)) begin
          bu_we = 1'b1;
          bu_wa = fb_r;
          bu_wd = sz_r + bu_q;
          nf_we = 1'b1;
          nf_wa = fb_r;
          nf_wd = fb_r;
          rover_nxt  = fb_r;
          res_st_nxt = ST_DONE;
          state_nxt  = S_DONE;
        end else begin
          rd_addr   = nx_r;
          state_nxt = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        nf_we = 1'b1;
        nf_wa = fb_r;
        if (fb_end == SUM_W'(nx_r)) begin
          // absorb the block above
          bu_we = 1'b1;
          bu_wa = fb_r;
          bu_wd = sz_r + bu_q;
          nf_wd = nf_q;
          fbsz_nxt   = sz_r + bu_q;
          fbnext_nxt = nf_q;
        end else begin
          nf_wd = nx_r;
          fbsz_nxt   = sz_r;
          fbnext_nxt = nx_r;
        end
        state_nxt = S_F_MERGE;
      end
      S_F_MERGE: begin
        nf_we = 1'b1;
        nf_wa = p_r;
        if ((SUM_W'(p_r) + SUM_W'(bup_r)) == SUM_W'(fb_r)) begin
          bu_we = 1'b1;
          bu_wa = p_r;
          bu_wd = bup_r + fbsz_r;
          nf_wd = fbnext_r;
        end else begin
          nf_wd = fb_r;
        end
        rover_nxt  = p_r;
        res_st_nxt = ST_DONE;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_addr_nxt   = res_hit_r ?
              base_r + (ADDR_W'(SIZE_W'(res_unit_r) + SIZE_W'(1)) << UNIT_SHIFT) : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_index == CFG_BASE_ADDRESS) begin
      base_nxt = cfg_data;
    end
    if (cfg_heap_we) begin
      heap_nxt       = heap_clamp;
      rover_nxt      = '0;
      list_valid_nxt = 1'b1;
      init_pend_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      init_pend_r  <= 1'b1;
      rover_r      <= '0;
      list_valid_r <= 1'b1;
      base_r       <= '0;
      heap_r       <= SIZE_W'(HEAP_UNITS_MAX);
      out_valid_r  <= 1'b0;
      res_hit_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      init_pend_r  <= init_pend_nxt;
      rover_r      <= rover_nxt;
      list_valid_r <= list_valid_nxt;
      base_r       <= base_nxt;
      heap_r       <= heap_nxt;
      out_valid_r  <= out_valid_nxt;
      res_hit_r    <= res_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    iter_r       <= iter_nxt;
    fb_r         <= fb_nxt;
    p_r          <= p_nxt;
    nx_r         <= nx_nxt;
    fbnext_r     <= fbnext_nxt;
    sz_r         <= sz_nxt;
    bup_r        <= bup_nxt;
    fbsz_r       <= fbsz_nxt;
    diff_r       <= diff_nxt;
    res_st_r     <= res_st_nxt;
    res_unit_r   <= res_unit_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  a_addr_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_DONE || out_addr_r == '0))
    else $error("nonzero address with failing status");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_rover_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !cfg_heap_we) |=> $stable(rover_r))
    else $error("rover moved with no item in flight");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_ready && bu_we && bu_wd == '0))
    else $error("clearing pass not exclusive");

endmodule
`default_nettype wire
